>>> rtl/core/trajectory_constraint_cost_defines.svh
// Assertion macros for the trajectory constraint cost block.
// Included by the top level only; no other dependencies.
`ifndef TRAJECTORY_CONSTRAINT_COST_DEFINES_SVH
`define TRAJECTORY_CONSTRAINT_COST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/tcc_pkg.sv
// Shared constants for the trajectory constraint cost block.
// Register indexes, reset values and fixed widths; no dependencies.
package tcc_pkg;

    localparam int SPEED_WIDTH = 16;
    localparam int SUM_W       = 40;
    localparam int COST_W      = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RMIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VMAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VMIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TSTEP    = 3'd6;

    localparam logic        RST_ENABLE   = 1'b1;
    localparam logic [2:0]  RST_EXPONENT = 3'd1;
    localparam logic [15:0] RST_WEIGHT   = 16'd1024;
    localparam logic [15:0] RST_RMIN     = 16'd819;
    localparam logic [15:0] RST_VMAX     = 16'd2048;
    localparam logic [15:0] RST_VMIN     = 16'hFA66;
    localparam logic [15:0] RST_TSTEP    = 16'd3277;

    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

endpackage

>>> rtl/core/trajectory_constraint_cost.sv
// Trajectory constraint cost: per-point violation scoring and row-end cost.
// Depends on tcc_pkg and trajectory_constraint_cost_defines.svh.
//
// Use: points arrive on the input channel (i_valid/o_ready) one beat each.
// Each point adds its speed and turning-radius violations to a 40-bit
// saturating row sum. A beat with i_row_last set closes the row and causes
// one result beat on the output channel (o_valid/i_ready); other beats
// cause none. While disabled, the last beat of a row returns the prior cost.
// Steps: a point passes through accept, limit check, 16 restoring division
// steps on the shared subtractor and radius update; a point whose
// quotient is known to exceed 16 bits skips the division.
// A row end uses the shared 32x32 multiplier for the scaled base (M0 to M5,
// then BASE), then PMUL and PSTEP per extra power step, and FIN for the total.
// The block takes no new point until the current one is finished.
// The result sits in an output register, so the next row proceeds while
// a result waits; only a second row end stalls behind an unaccepted beat.
// Reset (synchronous, active low) clears the row sum, the output slot and
// restores every configuration register to its default.
// Configuration writes (i_cfg_we) land at once; unknown indexes are dropped.
`include "trajectory_constraint_cost_defines.svh"

module trajectory_constraint_cost #(
    parameter int SPEED_WIDTH = tcc_pkg::SPEED_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tcc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tcc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [SPEED_WIDTH-1:0]     i_speed,
    input  logic signed [SPEED_WIDTH-1:0]     i_yaw_rate,
    input  logic [tcc_pkg::COST_W-1:0]        i_prior_cost,
    input  logic                              i_row_last,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tcc_pkg::COST_W-1:0]        o_row_cost,
    output logic                              o_saturated
);

    localparam int W  = SPEED_WIDTH;
    localparam int EW = ((W > 16) ? W : 16) + 1;
    localparam int SW = tcc_pkg::SUM_W;
    localparam int CW = tcc_pkg::COST_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LIMIT = 4'd1;
    localparam logic [3:0] S_DIV   = 4'd2;
    localparam logic [3:0] S_RAD   = 4'd3;
    localparam logic [3:0] S_M0    = 4'd4;
    localparam logic [3:0] S_M1    = 4'd5;
    localparam logic [3:0] S_M2    = 4'd6;
    localparam logic [3:0] S_M3    = 4'd7;
    localparam logic [3:0] S_M4    = 4'd8;
    localparam logic [3:0] S_M5    = 4'd9;
    localparam logic [3:0] S_BASE  = 4'd10;
    localparam logic [3:0] S_PMUL  = 4'd11;
    localparam logic [3:0] S_PSTEP = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    // configuration
    logic              r_enable;
    logic [2:0]        r_exp;
    logic [15:0]       r_weight;
    logic [15:0]       r_rmin;
    logic signed [15:0] r_vmax;
    logic signed [15:0] r_vmin;
    logic [15:0]       r_tstep;

    // control and row state
    logic [3:0]        r_state, n_state;
    logic [3:0]        r_cnt, n_cnt;
    logic [SW-1:0]     r_sum, n_sum;
    logic              r_sum_ovf, n_sum_ovf;
    logic              r_out_valid, n_out_valid;

    // datapath
    logic signed [W-1:0] r_vx, r_wz;
    logic [CW-1:0]     r_prior;
    logic              r_last;
    logic [W-1:0]      r_awz;
    logic              r_big;
    logic [W-1:0]      r_rem;
    logic [15:0]       r_low;
    logic [63:0]       r_prod;
    logic [63:0]       r_acc;
    logic [CW-1:0]     r_b;
    logic [CW-1:0]     r_pow;
    logic              r_sat;
    logic [CW-1:0]     r_out_cost;
    logic              r_out_sat;

    logic              in_beat;
    logic              load_ok;

    // speed limits
    logic signed [EW-1:0] vx_e, vmax_e, vmin_e, d_over, d_under;
    logic [EW-1:0]     over, under, viol;
    logic [W-1:0]      avx, awz_raw, awz;
    logic              big;

    // shared saturating adder on the row sum
    logic [EW-1:0]     add_op;
    logic [SW:0]       sum_add;

    // shared subtractor for the divider
    logic [W:0]        div_sh, div_trial;
    logic              div_ge;

    // shared multiplier
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;

    logic [2:0]        pwr;
    logic [CW:0]       total;

    assign in_beat = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);
    assign load_ok = !r_out_valid || i_ready;

    assign vx_e    = EW'(r_vx);
    assign vmax_e  = EW'(r_vmax);
    assign vmin_e  = EW'(r_vmin);
    assign d_over  = vx_e - vmax_e;
    assign d_under = vmin_e - vx_e;
    assign over    = (vx_e > vmax_e) ? d_over : '0;
    assign under   = (vmin_e > vx_e) ? d_under : '0;
    assign viol    = over + under;

    assign avx     = r_vx[W-1] ? W'(-r_vx) : W'(r_vx);
    assign awz_raw = r_wz[W-1] ? W'(-r_wz) : W'(r_wz);
    assign awz     = (awz_raw == '0) ? W'(1) : awz_raw;
    assign big     = {4'b0, avx} >= {awz, 4'b0};

    assign div_sh    = {r_rem, r_low[15]};
    assign div_trial = div_sh - {1'b0, r_awz};
    assign div_ge    = (div_sh >= {1'b0, r_awz});

    assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

    assign pwr   = (r_exp == 3'd0) ? 3'd1 : ((r_exp > 3'd4) ? 3'd4 : r_exp);
    assign total = {1'b0, r_prior} + {1'b0, r_pow};

    always_comb begin
        add_op = '0;
        if (r_state == S_LIMIT) begin
            add_op = viol;
        end else if (r_state == S_RAD && !r_big && (r_low < r_rmin)) begin
            add_op = EW'(r_rmin - r_low);
        end
    end

    assign sum_add = {1'b0, r_sum} + (SW+1)'(add_op);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_M0: begin
                mul_a = r_sum[31:0];
                mul_b = {16'b0, r_tstep};
            end
            S_M1: begin
                mul_a = 32'(r_sum[SW-1:32]);
                mul_b = {16'b0, r_tstep};
            end
            S_M3: begin
                mul_a = r_acc[43:12];
                mul_b = {16'b0, r_weight};
            end
            S_M4: begin
                mul_a = 32'(r_acc[55:44]);
                mul_b = {16'b0, r_weight};
            end
            S_PMUL: begin
                mul_a = r_pow;
                mul_b = r_b;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_sum       = r_sum;
        n_sum_ovf   = r_sum_ovf;
        n_out_valid = r_out_valid && !i_ready;
        unique case (r_state) inside
            S_IDLE: begin
                if (in_beat) begin
                    if (r_enable) begin
                        n_state = S_LIMIT;
                    end else if (i_row_last) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_LIMIT, S_RAD: begin
                if (sum_add[SW]) begin
                    n_sum     = tcc_pkg::SUM_MAX;
                    n_sum_ovf = 1'b1;
                end else begin
                    n_sum = sum_add[SW-1:0];
                end
                n_cnt = '0;
                if (r_state == S_LIMIT) begin
                    n_state = big ? S_RAD : S_DIV;
                end else begin
                    n_state = r_last ? S_M0 : S_IDLE;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_state = S_RAD;
                end
            end
            S_M0:   n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_BASE;
            S_BASE: begin
                n_cnt   = {1'b0, pwr - 3'd1};
                n_state = (pwr == 3'd1) ? S_FIN : S_PMUL;
            end
            S_PMUL: n_state = S_PSTEP;
            S_PSTEP: begin
                n_cnt   = r_cnt - 4'd1;
                n_state = (r_cnt == 4'd1) ? S_FIN : S_PMUL;
            end
            S_FIN: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_sum_ovf   = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_sum_ovf   <= 1'b0;
            r_out_valid <= 1'b0;
            r_enable    <= tcc_pkg::RST_ENABLE;
            r_exp       <= tcc_pkg::RST_EXPONENT;
            r_weight    <= tcc_pkg::RST_WEIGHT;
            r_rmin      <= tcc_pkg::RST_RMIN;
            r_vmax      <= tcc_pkg::RST_VMAX;
            r_vmin      <= tcc_pkg::RST_VMIN;
            r_tstep     <= tcc_pkg::RST_TSTEP;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_sum_ovf   <= n_sum_ovf;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcc_pkg::CFG_ENABLE:   r_enable <= i_cfg_data[0];
                    tcc_pkg::CFG_EXPONENT: r_exp    <= i_cfg_data[2:0];
                    tcc_pkg::CFG_WEIGHT:   r_weight <= i_cfg_data;
                    tcc_pkg::CFG_RMIN:     r_rmin   <= i_cfg_data;
                    tcc_pkg::CFG_VMAX:     r_vmax   <= i_cfg_data;
                    tcc_pkg::CFG_VMIN:     r_vmin   <= i_cfg_data;
                    tcc_pkg::CFG_TSTEP:    r_tstep  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state) inside
            S_IDLE: begin
                if (in_beat) begin
                    r_vx    <= i_speed;
                    r_wz    <= i_yaw_rate;
                    r_prior <= i_prior_cost;
                    r_last  <= i_row_last;
                    r_pow   <= '0;
                    r_sat   <= 1'b0;
                end
            end
            S_LIMIT: begin
                r_awz <= awz;
                r_big <= big;
                r_rem <= W'(avx >> 4);
                r_low <= {avx[3:0], 12'b0};
            end
            S_DIV: begin
                r_rem <= div_ge ? div_trial[W-1:0] : div_sh[W-1:0];
                r_low <= {r_low[14:0], div_ge};
            end
            S_M1, S_M4: r_acc <= r_prod;
            S_M2, S_M5: r_acc <= r_acc + {r_prod[31:0], 32'b0};
            S_BASE: begin
                r_b   <= (r_acc[63:40] != '0) ? tcc_pkg::COST_MAX : r_acc[39:8];
                r_pow <= (r_acc[63:40] != '0) ? tcc_pkg::COST_MAX : r_acc[39:8];
                r_sat <= r_sum_ovf || (r_acc[63:40] != '0);
            end
            S_PSTEP: begin
                r_pow <= (r_prod[63:48] != '0) ? tcc_pkg::COST_MAX : r_prod[47:16];
                r_sat <= r_sat || (r_prod[63:48] != '0);
            end
            S_FIN: begin
                if (load_ok) begin
                    r_out_cost <= total[CW] ? tcc_pkg::COST_MAX : total[CW-1:0];
                    r_out_sat  <= r_sat || total[CW];
                end
            end
            default: ;
        endcase
    end

    assign o_valid     = r_out_valid;
    assign o_row_cost  = r_out_cost;
    assign o_saturated = r_out_sat;

    `TCC_ASSERT_SAME(a_ovf_sticks, i_clk, i_rst_n, r_sum_ovf, r_sum == tcc_pkg::SUM_MAX, "row overflow flag set without saturated sum")
    `TCC_ASSERT_SAME(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_awz, "divider remainder not below divisor")
    `TCC_ASSERT_NEXT(a_row_clear, i_clk, i_rst_n, (r_state == S_FIN) && load_ok, (r_sum == '0) && !r_sum_ovf && o_valid, "row state not cleared on result load")
    `TCC_ASSERT_SAME(a_ready_busy, i_clk, i_rst_n, o_ready, (r_state != S_FIN) && (r_state != S_DIV), "input accepted while a point is in flight")

endmodule
